@@ hw/rtl/mbs_pkg.sv @@
// Shared types and constants for the motion block sequencer.
package mbs_pkg;

  // Program store geometry.
  localparam int MaxBlocks = 64;
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int PtrW      = 7;
  localparam int TicksW    = 32;

  // Register indexes on the configuration port.
  localparam logic CfgProgramLength = 1'b0;
  localparam logic CfgBusyGuard     = 1'b1;

  localparam logic [15:0] BusyGuardReset = 16'd150;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_ABORT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_HOME    = 3'd0,
    KIND_ABS     = 3'd1,
    KIND_REL     = 3'd2,
    KIND_VIBRATE = 3'd3,
    KIND_STOP    = 3'd4,
    KIND_SERVO   = 3'd5,
    KIND_WAIT    = 3'd6,
    KIND_NONE    = 3'd7
  } kind_e;

  // Stop-all command code; it shares its value with KIND_WAIT, which never issues a command.
  localparam logic [2:0] CmdStopAll = 3'd6;

  // One stored motion block.
  typedef struct packed {
    logic               first_only;
    logic signed [15:0] value_b;
    logic signed [31:0] value_a;
    logic [2:0]         target;
    kind_e              kind;
  } entry_t;

  // One classified input beat as queued between front and back.
  typedef struct packed {
    op_e             op;
    logic [2:0]      axis_busy;
    logic [IdxW-1:0] index;
    entry_t          entry;
    logic [15:0]     run_count;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic               all_done;
    logic               run_done;
    logic [15:0]        runs_remaining;
    logic [PtrW-1:0]    block_position;
    logic               is_running;
    logic signed [15:0] cmd_value_b;
    logic signed [31:0] cmd_value_a;
    logic [2:0]         cmd_target;
    logic [2:0]         cmd_kind;
    logic               cmd_valid;
  } result_t;

endpackage

@@ hw/rtl/mbs_front.sv @@
// Front end: accepts input beats and queues them for the back end.
module mbs_front import mbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output item_t q_item_o
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // Two-entry queue pointers and fill level.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

@@ hw/rtl/mbs_back.sv @@
// Back end: program store, sequencer state and the registered result beat.
module mbs_back import mbs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [PtrW-1:0] program_length_i,
  input  logic [15:0]     busy_guard_i,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  item_t           q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output result_t         out_res_o
);

  entry_t            mem [MaxBlocks];
  entry_t            rd_q;

  logic              active_q, active_d;
  logic [PtrW-1:0]   ptr_q, ptr_d;
  logic [15:0]       runs_q, runs_d;
  logic              first_q, first_d;
  logic              entered_q, entered_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;
  logic              out_valid_q;
  result_t           out_q, res;

  logic              fire;
  logic [PtrW-1:0]   len_eff;
  logic [TicksW-1:0] elapsed_inc;
  logic              axis_busy;
  logic              block_done;
  logic [15:0]       runs_dec;
  logic              mem_we;

  assign fire        = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Lengths past the store size act as the full store.
  assign len_eff = (program_length_i > PtrW'(MaxBlocks)) ? PtrW'(MaxBlocks)
                                                         : program_length_i;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TicksW'(1);
  assign runs_dec    = (runs_q != 16'd0) ? runs_q - 16'd1 : runs_q;
  assign axis_busy   = (rd_q.target < 3'd3) ? q_item_i.axis_busy[rd_q.target[1:0]] : 1'b0;

  // Completion test for a block that was already entered.
  always_comb begin
    case (rd_q.kind)
      KIND_HOME, KIND_ABS, KIND_REL: begin
        block_done = (elapsed_inc >= TicksW'(busy_guard_i)) && !axis_busy;
      end
      KIND_WAIT: begin
        block_done = (elapsed_inc >= rd_q.value_a);
      end
      default: begin
        block_done = 1'b1;
      end
    endcase
  end

  // One update step per dequeued beat.
  always_comb begin
    active_d  = active_q;
    ptr_d     = ptr_q;
    runs_d    = runs_q;
    first_d   = first_q;
    entered_d = entered_q;
    elapsed_d = elapsed_q;
    mem_we    = 1'b0;
    res       = '0;
    if (fire) begin
      case (q_item_i.op)
        OP_TICK: begin
          if (active_q) begin
            if (ptr_q >= len_eff) begin
              // End of one pass through the list.
              runs_d       = runs_dec;
              res.run_done = 1'b1;
              if (runs_dec != 16'd0) begin
                first_d   = 1'b0;
                ptr_d     = '0;
                entered_d = 1'b0;
              end else begin
                active_d     = 1'b0;
                res.all_done = 1'b1;
              end
            end else if (rd_q.first_only && !first_q) begin
              ptr_d     = ptr_q + PtrW'(1);
              entered_d = 1'b0;
            end else if (!entered_q) begin
              // Entry tick issues the block's command, if its kind has one (not WAIT or NONE).
              if (rd_q.kind != KIND_WAIT && rd_q.kind != KIND_NONE) begin
                res.cmd_valid  = 1'b1;
                res.cmd_kind   = rd_q.kind;
                res.cmd_target = rd_q.target;
                if (rd_q.kind == KIND_ABS || rd_q.kind == KIND_REL ||
                    rd_q.kind == KIND_VIBRATE) begin
                  res.cmd_value_a = rd_q.value_a;
                  res.cmd_value_b = rd_q.value_b;
                end else if (rd_q.kind == KIND_SERVO) begin
                  res.cmd_value_a = {16'd0, rd_q.value_a[15:0]};
                end
              end
              elapsed_d = '0;
              entered_d = 1'b1;
            end else begin
              elapsed_d = elapsed_inc;
              if (block_done) begin
                ptr_d     = ptr_q + PtrW'(1);
                entered_d = 1'b0;
              end
            end
          end
        end
        OP_WRITE: begin
          mem_we = !active_q;
        end
        OP_START: begin
          if (len_eff != '0) begin
            runs_d    = (q_item_i.run_count == 16'd0) ? 16'd1 : q_item_i.run_count;
            ptr_d     = '0;
            first_d   = 1'b1;
            entered_d = 1'b0;
            active_d  = 1'b1;
          end
        end
        OP_ABORT: begin
          active_d     = 1'b0;
          res.cmd_valid = 1'b1;
          res.cmd_kind  = CmdStopAll;
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
    res.is_running     = active_d;
    res.block_position = ptr_d;
    res.runs_remaining = runs_d;
  end

  // Sequencer state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      ptr_q       <= '0;
      runs_q      <= 16'd0;
      first_q     <= 1'b1;
      entered_q   <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      ptr_q     <= ptr_d;
      runs_q    <= runs_d;
      first_q   <= first_d;
      entered_q <= entered_d;
      elapsed_q <= elapsed_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // Program store; the read follows the next pointer so the entry is ready in time.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[q_item_i.index] <= q_item_i.entry;
    end
    rd_q <= mem[ptr_d[IdxW-1:0]];
  end

endmodule

@@ hw/rtl/motion_block_sequencer.sv @@
// Top level of the motion block sequencer.
// Runs a stored list of up to 64 motion blocks. Each input beat (tick, write entry,
// start or abort, selected by s_axis_tuser) yields exactly one result beat carrying
// an optional device command and the sequencer state after the step. While the result
// output is not stalled, a beat can be accepted every clock cycle: a two-entry queue
// separates the front from the executing back, and the back handles one beat per cycle
// from a registered read of the program store, with the result held in an output register.
// A beat passes a queue slot, then the output register. Entries are written only while no
// run is active; the user must write configuration while the block is idle (not enforced).
module motion_block_sequencer import mbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: axis_busy[2:0], entry_index[8:3], entry_kind[11:9], entry_target[14:12],
  //   entry_value_a[46:15], entry_value_b[62:47], entry_first_only[63], run_count[79:64]
  input  logic [79:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: cmd_valid[0], cmd_kind[3:1], cmd_target[6:4], cmd_value_a[38:7],
  //   cmd_value_b[54:39], is_running[55], block_position[62:56], runs_remaining[78:63],
  //   run_done[79], all_done[80], zero fill[87:81]
  output logic [87:0] m_axis_tdata
);

  logic [PtrW-1:0] program_length_q;
  logic [15:0]     busy_guard_q;
  item_t           in_item, q_item;
  logic            q_valid, q_ready;
  result_t         res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_length_q <= '0;
      busy_guard_q     <= BusyGuardReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgProgramLength) begin
        program_length_q <= cfg_data_i[PtrW-1:0];
      end else begin
        busy_guard_q <= cfg_data_i;
      end
    end
  end

  // Unpack the input beat.
  always_comb begin
    in_item                  = '0;
    in_item.op               = op_e'(s_axis_tuser);
    in_item.axis_busy        = s_axis_tdata[2:0];
    in_item.index            = s_axis_tdata[8:3];
    in_item.entry.kind       = kind_e'(s_axis_tdata[11:9]);
    in_item.entry.target     = s_axis_tdata[14:12];
    in_item.entry.value_a    = s_axis_tdata[46:15];
    in_item.entry.value_b    = s_axis_tdata[62:47];
    in_item.entry.first_only = s_axis_tdata[63];
    in_item.run_count        = s_axis_tdata[79:64];
  end

  mbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  mbs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .program_length_i (program_length_q),
    .busy_guard_i     (busy_guard_q),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_item_i         (q_item),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_res_o        (res)
  );

  // Pack the result beat.
  assign m_axis_tdata = {7'd0, res.all_done, res.run_done, res.runs_remaining,
                         res.block_position, res.is_running, res.cmd_value_b,
                         res.cmd_value_a, res.cmd_target, res.cmd_kind, res.cmd_valid};

endmodule

@@ sim/motion_block_sequencer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the motion block sequencer with a built-in predictor.
module motion_block_sequencer_test;
  import mbs_pkg::*;

  localparam int WatchdogLimit = 5000;

  // Ports of the block; every input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgProgramLength;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  motion_block_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of the program, the registers and the sequencing state.
  entry_t      prog_store [MaxBlocks];
  logic [6:0]  prog_len = '0;
  logic [15:0] guard_ticks = BusyGuardReset;
  logic        seq_active = 1'b0;
  logic [6:0]  blk_ptr = '0;
  logic [15:0] runs_left = '0;
  logic        first_pass = 1'b1;
  logic        entered = 1'b0;
  logic [31:0] elapsed = '0;

  // Beats waiting to be sent and result beats still owed by the block.
  item_t   pending_beats [$];
  item_t   cur_beat;
  result_t expected_results [$];

  bit gaps_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int stuck_cycles = 0;
  int beats_queued = 0;
  int beats_in = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cmds_seen = 0;
  int passes_seen = 0;
  int sequences_seen = 0;

  // Advances the predicted sequencer by one beat and returns the result it owes.
  function automatic result_t sequencer_step(input item_t beat);
    result_t    r;
    entry_t     e;
    logic [6:0] eff;
    logic       axis_held;
    logic       fin;
    r = '0;
    eff = (prog_len > 7'(MaxBlocks)) ? 7'(MaxBlocks) : prog_len;
    case (beat.op)
      OP_TICK: begin
        if (seq_active) begin
          if (blk_ptr >= eff) begin
            // End of a pass: either wrap for the next one or stop.
            if (runs_left != 0) runs_left--;
            r.run_done = 1'b1;
            if (runs_left != 0) begin
              first_pass = 1'b0;
              blk_ptr = '0;
              entered = 1'b0;
            end else begin
              seq_active = 1'b0;
              r.all_done = 1'b1;
            end
          end else begin
            e = prog_store[blk_ptr[5:0]];
            if (e.first_only && !first_pass) begin
              blk_ptr++;
              entered = 1'b0;
            end else if (!entered) begin
              // Entry tick: issue the block's command, if its kind has one, and restart the timer.
              if (e.kind <= KIND_SERVO) begin
                r.cmd_valid = 1'b1;
                r.cmd_kind = e.kind;
                r.cmd_target = e.target;
                if (e.kind == KIND_ABS || e.kind == KIND_REL || e.kind == KIND_VIBRATE) begin
                  r.cmd_value_a = e.value_a;
                  r.cmd_value_b = e.value_b;
                end else if (e.kind == KIND_SERVO) begin
                  r.cmd_value_a = {16'd0, e.value_a[15:0]};
                end
              end
              elapsed = '0;
              entered = 1'b1;
            end else begin
              // Later ticks: count up, then decide whether the block is finished.
              if (elapsed != '1) elapsed++;
              if (e.kind <= KIND_REL) begin
                axis_held = (e.target < 3'd3) ? beat.axis_busy[e.target] : 1'b0;
                fin = (elapsed >= 32'(guard_ticks)) && !axis_held;
              end else if (e.kind == KIND_WAIT) begin
                fin = elapsed >= $unsigned(e.value_a);
              end else begin
                fin = 1'b1;
              end
              if (fin) begin
                blk_ptr++;
                entered = 1'b0;
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (!seq_active) prog_store[beat.index] = beat.entry;
      end
      OP_START: begin
        if (eff != '0) begin
          runs_left = (beat.run_count == '0) ? 16'd1 : beat.run_count;
          blk_ptr = '0;
          first_pass = 1'b1;
          entered = 1'b0;
          seq_active = 1'b1;
        end
      end
      default: begin
        seq_active = 1'b0;
        r.cmd_valid = 1'b1;
        r.cmd_kind = CmdStopAll;
      end
    endcase
    r.is_running = seq_active;
    r.block_position = blk_ptr;
    r.runs_remaining = runs_left;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("cmd=%0b kind=%0d tgt=%0d a=%h b=%h run=%0b pos=%0d left=%0d pass=%0b all=%0b",
                     r.cmd_valid, r.cmd_kind, r.cmd_target, r.cmd_value_a, r.cmd_value_b,
                     r.is_running, r.block_position, r.runs_remaining, r.run_done, r.all_done);
  endfunction

  // Random block entry; wait blocks mostly get short delays so that runs move on.
  function automatic entry_t rand_entry();
    entry_t e;
    e.kind = kind_e'($urandom_range(0, 7));
    e.target = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
    e.value_a = $urandom();
    if (e.kind == KIND_WAIT && $urandom_range(0, 9) != 0) e.value_a = $urandom_range(0, 6);
    e.value_b = 16'($urandom());
    e.first_only = ($urandom_range(0, 3) == 0);
    return e;
  endfunction

  // Beat with every field random; callers overwrite what matters.
  function automatic item_t rand_beat();
    item_t b;
    b.op = op_e'($urandom_range(0, 3));
    b.axis_busy = 3'($urandom());
    b.index = 6'($urandom());
    b.entry = rand_entry();
    b.run_count = 16'($urandom());
    return b;
  endfunction

  function automatic logic [2:0] rand_busy();
    return ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom());
  endfunction

  task automatic push_beat(input item_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // One program session (now and then just a single random beat): up to four entry writes,
  // a start, a stretch of ticks with the odd abort, restart or stray write, and often a closing abort.
  task automatic push_session();
    item_t b;
    int    n;
    b = rand_beat();
    if ($urandom_range(0, 9) == 0) begin
      push_beat(b);
      return;
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      b = rand_beat();
      b.op = OP_WRITE;
      push_beat(b);
    end
    b = rand_beat();
    b.op = OP_START;
    case ($urandom_range(0, 7))
      0: b.run_count = '0;
      1: ;
      default: b.run_count = 16'($urandom_range(1, 3));
    endcase
    push_beat(b);
    n = $urandom_range(8, 60);
    repeat (n) begin
      b = rand_beat();
      case ($urandom_range(0, 49))
        0: b.op = OP_ABORT;
        1: begin
          b.op = OP_START;
          b.run_count = 16'($urandom_range(0, 3));
        end
        2: b.op = OP_WRITE;
        default: begin
          b.op = OP_TICK;
          b.axis_busy = rand_busy();
        end
      endcase
      push_beat(b);
    end
    if ($urandom_range(0, 1) != 0) begin
      b = rand_beat();
      b.op = OP_ABORT;
      push_beat(b);
    end
  endtask

  // Waits until every beat is sent and answered, then lets the pipeline settle.
  task automatic drain();
    while (pending_beats.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == CfgProgramLength) prog_len = data[6:0];
    else guard_ticks = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [6:0] len, input logic [15:0] guard, input bit gaps,
                           input int beats);
    int goal;
    drain();
    cfg_write(CfgProgramLength, {9'd0, len});
    cfg_write(CfgBusyGuard, guard);
    @(negedge clk_i);
    gaps_on = gaps;
    goal = beats_queued + beats;
    while (beats_queued < goal) push_session();
  endtask

  // Beat driver: predicts each accepted beat and presents the next pending one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(sequencer_step(cur_beat));
        beats_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tdata <= {cur_beat.run_count, cur_beat.entry, cur_beat.index,
                           cur_beat.axis_busy};
          s_axis_tuser <= cur_beat.op;
          s_axis_tvalid <= 1'b1;
          if (gaps_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result beat against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[80:0]);
        results_seen++;
        if (got.cmd_valid) cmds_seen++;
        if (got.run_done) passes_seen++;
        if (got.all_done) sequences_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result beat: %s", show(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_axis_tdata[87:81] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d\n  expected %s\n  actual   %s fill=%h",
                       results_seen, show(want), show(got), m_axis_tdata[87:81]);
          end
        end
      end
      // Receiver back-pressure in random bursts.
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (gaps_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("ERROR: no beat accepted for %0d cycles", WatchdogLimit);
        $display("motion_block_sequencer verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    item_t b;
    int    i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Idle block with an empty program: tick does nothing, abort still stops
    // all axes, and a start is refused.
    b = rand_beat();
    b.op = OP_TICK;
    push_beat(b);
    b = rand_beat();
    b.op = OP_ABORT;
    push_beat(b);
    b = rand_beat();
    b.op = OP_START;
    b.run_count = 16'd5;
    push_beat(b);

    // Load every entry so no run ever reads an empty slot; the first nine
    // cover each kind and the extremes of the values.
    for (i = 0; i < MaxBlocks; i++) begin
      b = rand_beat();
      b.op = OP_WRITE;
      b.index = 6'(i);
      if (i < 9) b.entry.first_only = (i == 0 || i == 8);
      case (i)
        0: begin
          b.entry.kind = KIND_HOME;
          b.entry.target = 3'd5;
        end
        1: begin
          b.entry.kind = KIND_ABS;
          b.entry.target = 3'd0;
          b.entry.value_a = 32'h7fff_ffff;
          b.entry.value_b = 16'h7fff;
        end
        2: begin
          b.entry.kind = KIND_REL;
          b.entry.target = 3'd1;
          b.entry.value_a = 32'h8000_0000;
          b.entry.value_b = 16'h8000;
        end
        3: begin
          b.entry.kind = KIND_VIBRATE;
          b.entry.target = 3'd2;
          b.entry.value_a = '1;
          b.entry.value_b = '1;
        end
        4: begin
          b.entry.kind = KIND_SERVO;
          b.entry.target = 3'd7;
          b.entry.value_a = 32'habcd_1234;
        end
        5: begin
          b.entry.kind = KIND_STOP;
          b.entry.target = 3'd3;
        end
        6: begin
          b.entry.kind = KIND_WAIT;
          b.entry.target = 3'd7;
          b.entry.value_a = 32'd3;
        end
        7: b.entry.kind = KIND_NONE;
        8: begin
          b.entry.kind = KIND_WAIT;
          b.entry.value_a = '0;
        end
        default: ;
      endcase
      push_beat(b);
    end

    // Zero runs count as one, a write during the run is dropped, ticks with and without
    // busy axes are mixed in, and a second start restarts the running sequence.
    drain();
    cfg_write(CfgProgramLength, 16'd9);
    cfg_write(CfgBusyGuard, 16'd2);
    @(negedge clk_i);
    b = rand_beat();
    b.op = OP_START;
    b.run_count = '0;
    push_beat(b);
    b = rand_beat();
    b.op = OP_WRITE;
    push_beat(b);
    for (i = 0; i < 12; i++) begin
      b = rand_beat();
      b.op = OP_TICK;
      b.axis_busy = (i % 6 < 2) ? 3'b111 : 3'b000;
      push_beat(b);
    end
    b = rand_beat();
    b.op = OP_START;
    b.run_count = 16'd2;
    push_beat(b);

    // Three runs, then the program is shortened under the running sequence so
    // the pointer lies past the end; the first-only block is skipped later on.
    b = rand_beat();
    b.op = OP_START;
    b.run_count = 16'd3;
    push_beat(b);
    for (i = 0; i < 6; i++) begin
      b = rand_beat();
      b.op = OP_TICK;
      b.axis_busy = '0;
      push_beat(b);
    end
    drain();
    cfg_write(CfgProgramLength, 16'd1);
    @(negedge clk_i);
    for (i = 0; i < 6; i++) begin
      b = rand_beat();
      b.op = OP_TICK;
      push_beat(b);
    end
    b = rand_beat();
    b.op = OP_ABORT;
    push_beat(b);

    // Random sessions over a spread of register settings.
    run_phase(7'd9, 16'd2, 1'b1, 260);
    run_phase(7'd64, 16'd0, 1'b1, 260);
    run_phase(7'd127, 16'd1, 1'b0, 260);
    run_phase(7'd0, 16'd5, 1'b1, 60);
    run_phase(7'd3, 16'd65535, 1'b1, 260);
    run_phase(7'd20, 16'd150, 1'b1, 260);
    run_phase(7'($urandom_range(1, 12)), 16'($urandom_range(0, 6)), 1'b0, 260);

    drain();
    $display("Run covered %0d input beats and %0d result beats: %0d device commands,",
             beats_in, results_seen, cmds_seen);
    $display("  %0d completed passes and %0d finished sequences over a spread of settings.",
             passes_seen, sequences_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("motion_block_sequencer verification clean");
    end else begin
      $display("motion_block_sequencer verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mbs_pkg.sv
hw/rtl/mbs_front.sv
hw/rtl/mbs_back.sv
hw/rtl/motion_block_sequencer.sv
sim/motion_block_sequencer_test.sv
